// File: rtl/core/bicubic_alpha_upscale_core_macros.svh
// Assertion macros used by the upscaler controller
`ifndef BICUBIC_ALPHA_UPSCALE_CORE_MACROS_SVH
`define BICUBIC_ALPHA_UPSCALE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BAU_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset
`define BAU_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: rtl/core/bau_pkg.sv
// Shared constants, types and helpers of the bicubic alpha upscaler
`timescale 1ns / 1ps
package bau_pkg;

   localparam int MAX_SOURCE_SIDE = 1024;
   localparam int MAX_TARGET_SIDE = 4096;
   localparam int SAMPLE_BITS     = 16;

   localparam int SRC_IDX_BITS    = $clog2(MAX_SOURCE_SIDE);
   localparam int STORE_DEPTH     = MAX_SOURCE_SIDE * MAX_SOURCE_SIDE;
   localparam int STORE_ADDR_BITS = 2 * SRC_IDX_BITS;
   localparam int SRC_SIZE_BITS   = 11;
   localparam int TGT_SIZE_BITS   = 13;
   localparam int COORD_BITS      = 12;
   localparam int CSR_DATA_BITS   = 13;
   localparam int CSR_IDX_BITS    = 2;
   localparam int DIVIDEND_BITS   = 64;
   localparam int DIVISOR_BITS    = 48;
   localparam int DIV_CNT_BITS    = 7;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SOURCE_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TARGET_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TARGET_HEIGHT = 2'd3;

   // request opcodes
   localparam logic OP_WRITE   = 1'b0;
   localparam logic OP_COMPUTE = 1'b1;

   // quotient widths for the two division jobs
   localparam logic [DIV_CNT_BITS-1:0] POS_QUOT_BITS = 7'd40;
   localparam logic [DIV_CNT_BITS-1:0] FIN_QUOT_BITS = 7'd8;

   typedef enum logic [1:0] {
      DIV_POSX,
      DIV_POSY,
      DIV_FINAL
   } div_sel_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_FULL,
      RES_DIV
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        div_start;
      div_sel_type div_sel;
      logic        kern_en;
      logic [4:0]  kern_step;
      logic        acc_clear;
      logic        tap_en;
      logic [3:0]  tap_idx;
      logic        norm_load;
      logic        res_load;
      res_sel_type res_sel;
      logic        out_load;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic pipe_busy;
      logic res_zero;
      logic res_full;
      logic rsp_busy;
   } sts_type;

   // zero counts as one, oversize saturates
   function automatic logic [SRC_SIZE_BITS-1:0] eff_src(logic [SRC_SIZE_BITS-1:0] v);
      logic [SRC_SIZE_BITS-1:0] r;
      if (v == '0) r = SRC_SIZE_BITS'(1);
      else if (v > SRC_SIZE_BITS'(MAX_SOURCE_SIDE)) r = SRC_SIZE_BITS'(MAX_SOURCE_SIDE);
      else r = v;
      return r;
   endfunction

   function automatic logic [TGT_SIZE_BITS-1:0] eff_tgt(logic [TGT_SIZE_BITS-1:0] v);
      logic [TGT_SIZE_BITS-1:0] r;
      if (v == '0) r = TGT_SIZE_BITS'(1);
      else if (v > TGT_SIZE_BITS'(MAX_TARGET_SIDE)) r = TGT_SIZE_BITS'(MAX_TARGET_SIDE);
      else r = v;
      return r;
   endfunction

endpackage

// File: rtl/core/bicubic_alpha_upscale_core.sv
// Top level of the bicubic alpha upscaler
`timescale 1ns / 1ps
// Bicubic alpha upscaler. A write beat (opcode 0) stores one signed Q3.12 sample
// in the on-chip 1024 x 1024 mask store and gives no response; writes outside
// the configured source size are dropped. A compute beat (opcode 1) gives one
// alpha byte for a destination pixel: two 40-step position divisions on the
// shared restoring divider, kernel weights in four steps each on one multiplier
// chain, sixteen reads from the single read port of the store, a short drain,
// and an 8-step final division. One request is in flight at a time; a finished
// byte waits in the output register while the next request is taken. No clearing
// pass: a store entry must be written before any compute reads it. The user
// must write size registers only when the block is idle; it does not check this.
module bicubic_alpha_upscale_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [bau_pkg::COORD_BITS-1:0]    req_coord_x,
   input  logic [bau_pkg::COORD_BITS-1:0]    req_coord_y,
   input  logic signed [15:0]                req_alpha_sample,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [7:0]                        rsp_alpha_byte,
   input  logic                              csr_write_enable,
   input  logic [bau_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [bau_pkg::CSR_DATA_BITS-1:0] csr_write_data
);
   import bau_pkg::*;

   cmd_type cmd;
   sts_type sts;

   bau_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .cmd        (cmd),
      .sts        (sts)
   );

   bau_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_opcode       (req_opcode),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_alpha_sample (req_alpha_sample),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_alpha_byte   (rsp_alpha_byte),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

endmodule

// File: rtl/core/bau_ram.sv
// Generic simple dual-port RAM with registered read
`timescale 1ns / 1ps
module bau_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write and read, read data registered
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/bau_div.sv
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module bau_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [bau_pkg::DIVIDEND_BITS-1:0]   dividend,
   input  logic [bau_pkg::DIVISOR_BITS-1:0]    divisor,
   input  logic [bau_pkg::DIV_CNT_BITS-1:0]    nbits,
   output logic                                done,
   output logic [bau_pkg::DIVIDEND_BITS-1:0]   quotient
);
   import bau_pkg::*;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DIV_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_BITS-1:0] sh_ff, sh_in;
   logic [DIVISOR_BITS:0]    trial;
   logic                     ge;

   // one compare and subtract per step
   always_comb begin
      trial = {rem_ff, sh_ff[DIVIDEND_BITS-1]};
      ge    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      sh_in   = sh_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = nbits;
         dsr_in  = divisor;
         rem_in  = DIVISOR_BITS'(dividend >> nbits);
         sh_in   = dividend << (DIV_CNT_BITS'(DIVIDEND_BITS) - nbits);
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_BITS'(trial - {1'b0, dsr_ff}) : trial[DIVISOR_BITS-1:0];
         sh_in  = {sh_ff[DIVIDEND_BITS-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      sh_ff  <= sh_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

// File: rtl/core/bau_dp.sv
// Datapath: store, coordinate mapping, kernel weights, accumulation and result
`timescale 1ns / 1ps
module bau_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bau_pkg::cmd_type                      cmd,
   output bau_pkg::sts_type                      sts,
   input  logic                                  req_opcode,
   input  logic [bau_pkg::COORD_BITS-1:0]        req_coord_x,
   input  logic [bau_pkg::COORD_BITS-1:0]        req_coord_y,
   input  logic signed [15:0]                    req_alpha_sample,
   input  logic                                  rsp_stall,
   output logic                                  rsp_valid,
   output logic [7:0]                            rsp_alpha_byte,
   input  logic                                  csr_write_enable,
   input  logic [bau_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [bau_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);
   import bau_pkg::*;

   // configuration
   logic [SRC_SIZE_BITS-1:0] src_w_ff, src_h_ff, sw, sh;
   logic [TGT_SIZE_BITS-1:0] tgt_w_ff, tgt_h_ff, dw, dh;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SRC_SIZE_BITS'(1024);
         src_h_ff <= SRC_SIZE_BITS'(1024);
         tgt_w_ff <= TGT_SIZE_BITS'(1024);
         tgt_h_ff <= TGT_SIZE_BITS'(1024);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SOURCE_WIDTH:  src_w_ff <= csr_write_data[SRC_SIZE_BITS-1:0];
            CSR_SOURCE_HEIGHT: src_h_ff <= csr_write_data[SRC_SIZE_BITS-1:0];
            CSR_TARGET_WIDTH:  tgt_w_ff <= csr_write_data;
            CSR_TARGET_HEIGHT: tgt_h_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign sw = eff_src(src_w_ff);
   assign sh = eff_src(src_h_ff);
   assign dw = eff_tgt(tgt_w_ff);
   assign dh = eff_tgt(tgt_h_ff);

   // capture the request beat
   logic [COORD_BITS-1:0] x_ff, y_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_coord_x;
         y_ff <= req_coord_y;
      end
   end

   // store: writes land in the accept cycle
   logic                       ram_we;
   logic [STORE_ADDR_BITS-1:0] ram_waddr, ram_raddr;
   logic [SAMPLE_BITS-1:0]     ram_rdata;

   assign ram_we = cmd.capture && (req_opcode == OP_WRITE)
                   && (req_coord_x < COORD_BITS'(sw))
                   && (req_coord_y < COORD_BITS'(sh));
   assign ram_waddr = {req_coord_y[SRC_IDX_BITS-1:0], req_coord_x[SRC_IDX_BITS-1:0]};

   bau_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (SAMPLE_BITS'(req_alpha_sample)),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // divider operands
   logic [12:0]              odd_c;
   logic [23:0]              scale_p;
   logic [TGT_SIZE_BITS-1:0] dst_side;
   logic [SRC_SIZE_BITS-1:0] src_side;
   logic [DIVIDEND_BITS-1:0] div_num;
   logic [DIVISOR_BITS-1:0]  div_den;
   logic [DIV_CNT_BITS-1:0]  div_n;
   logic                     div_done;
   logic [DIVIDEND_BITS-1:0] div_q;
   logic signed [55:0]       abs_sum_ff;
   logic signed [39:0]       abs_norm_ff;

   always_comb begin
      src_side = (cmd.div_sel == DIV_POSY) ? sh : sw;
      dst_side = (cmd.div_sel == DIV_POSY) ? dh : dw;
      odd_c    = (cmd.div_sel == DIV_POSY) ? {y_ff, 1'b1} : {x_ff, 1'b1};
      scale_p  = odd_c * src_side;
      if (cmd.div_sel == DIV_FINAL) begin
         div_num = 64'(abs_sum_ff[47:0]) * 64'(510) + 64'({abs_norm_ff[39:0], 12'b0});
         div_den = DIVISOR_BITS'({abs_norm_ff[34:0], 13'b0});
         div_n   = FIN_QUOT_BITS;
      end else begin
         div_num = 64'({scale_p, 16'b0}) + 64'(dst_side);
         div_den = DIVISOR_BITS'({dst_side, 1'b0});
         div_n   = POS_QUOT_BITS;
      end
   end

   bau_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .nbits    (div_n),
      .done     (div_done),
      .quotient (div_q)
   );

   // positions, offset by one source pixel so they stay non-negative
   logic [39:0] posx_ff, posy_ff;

   always_ff @(posedge clock) begin
      if (div_done && cmd.div_sel == DIV_POSX) begin
         posx_ff <= div_q[39:0] + 40'd32768;
      end
      if (div_done && cmd.div_sel == DIV_POSY) begin
         posy_ff <= div_q[39:0] + 40'd32768;
      end
   end

   // kernel: distance, square, cube, round, four steps per weight
   logic [2:0]          kidx;
   logic [1:0]          kphase;
   logic [15:0]         frac;
   logic [17:0]         kdist;
   logic [17:0]         d_ff;
   logic [35:0]         d2_ff;
   logic [53:0]         d3_ff;
   logic signed [63:0]  ds, d2s, d3s, br1, br2, w49, wq;
   logic signed [15:0]  wr;
   logic signed [15:0]  wx_ff [4];
   logic signed [15:0]  wy_ff [4];

   assign kidx   = cmd.kern_step[4:2];
   assign kphase = cmd.kern_step[1:0];

   always_comb begin
      frac = kidx[2] ? posy_ff[15:0] : posx_ff[15:0];
      case (kidx[1:0])
         2'd0:    kdist = 18'd65536 + 18'(frac);
         2'd1:    kdist = 18'(frac);
         2'd2:    kdist = 18'd65536 - 18'(frac);
         default: kdist = 18'd131072 - 18'(frac);
      endcase
      ds  = $signed(64'(d_ff));
      d2s = $signed(64'(d2_ff));
      d3s = $signed(64'(d3_ff));
      br1 = 64'sd3 * d3s - 64'sd5 * (d2s <<< 16) + (64'sd1 <<< 49);
      br2 = 64'sd5 * (d2s <<< 16) - d3s - 64'sd8 * (ds <<< 32) + (64'sd1 <<< 50);
      w49 = (d_ff < 18'd65536) ? br1 : br2;
      wq  = (w49 + (64'sd1 <<< 34) + (64'sd1 <<< 49)) >>> 35;
      if (d_ff >= 18'd131072) wr = '0;
      else wr = 16'(wq - 64'sd16384);
   end

   always_ff @(posedge clock) begin
      if (cmd.kern_en) begin
         case (kphase)
            2'd0: d_ff  <= kdist;
            2'd1: d2_ff <= d_ff * d_ff;
            2'd2: d3_ff <= 54'(d2_ff * d_ff);
            default: begin
               if (kidx[2]) wy_ff[kidx[1:0]] <= wr;
               else wx_ff[kidx[1:0]] <= wr;
            end
         endcase
      end
   end

   // clamp a neighbour index to the source edge
   function automatic logic [SRC_IDX_BITS-1:0] clamp_idx(logic [23:0] p, logic [1:0] k,
                                                         logic [SRC_SIZE_BITS-1:0] side);
      logic signed [25:0]       v;
      logic [SRC_SIZE_BITS-1:0] top;
      logic [SRC_IDX_BITS-1:0]  r;
      v   = $signed({2'b0, p}) + $signed({24'b0, k}) - 26'sd2;
      top = side - 1'b1;
      if (v < 0) r = '0;
      else if (v > $signed({15'b0, top})) r = top[SRC_IDX_BITS-1:0];
      else r = v[SRC_IDX_BITS-1:0];
      return r;
   endfunction

   assign ram_raddr = {clamp_idx(posy_ff[39:16], cmd.tap_idx[3:2], sh),
                       clamp_idx(posx_ff[39:16], cmd.tap_idx[1:0], sw)};

   // tap pipeline: read, weight, product, accumulate
   logic               v1_ff, v2_ff, v3_ff;
   logic [3:0]         k1_ff;
   logic signed [15:0] smp_ff;
   logic signed [31:0] wt_ff, wn_ff;
   logic signed [47:0] prod_ff;
   logic signed [55:0] sum_ff;
   logic signed [39:0] norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.tap_en;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      k1_ff   <= cmd.tap_idx;
      smp_ff  <= $signed(ram_rdata);
      wt_ff   <= wy_ff[k1_ff[3:2]] * wx_ff[k1_ff[1:0]];
      prod_ff <= smp_ff * wt_ff;
      wn_ff   <= wt_ff;
      if (cmd.acc_clear) begin
         sum_ff  <= '0;
         norm_ff <= '0;
      end else if (v3_ff) begin
         sum_ff  <= sum_ff + 56'(prod_ff);
         norm_ff <= norm_ff + 40'(wn_ff);
      end
   end

   // fold a negative weight total
   always_ff @(posedge clock) begin
      if (cmd.norm_load) begin
         if (norm_ff < 0) begin
            abs_sum_ff  <= -sum_ff;
            abs_norm_ff <= -norm_ff;
         end else begin
            abs_sum_ff  <= sum_ff;
            abs_norm_ff <= norm_ff;
         end
      end
   end

   // result and output register
   logic [7:0] res_ff;
   logic [7:0] rsp_byte_ff;
   logic       rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         case (cmd.res_sel)
            RES_ZERO: res_ff <= 8'd0;
            RES_FULL: res_ff <= 8'd255;
            default:  res_ff <= div_q[7:0];
         endcase
      end
      if (cmd.out_load) begin
         rsp_byte_ff <= res_ff;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_alpha_byte = rsp_byte_ff;

   // status back to the controller
   always_comb begin
      sts.div_done  = div_done;
      sts.pipe_busy = v1_ff | v2_ff | v3_ff;
      sts.res_zero  = (abs_norm_ff == '0) || (abs_sum_ff <= 0);
      sts.res_full  = abs_sum_ff >= $signed({4'b0, abs_norm_ff, 12'b0});
      sts.rsp_busy  = rsp_valid_ff && rsp_stall;
   end

endmodule

// File: rtl/core/bau_ctrl.sv
// Controller: sequences one request through the datapath
`timescale 1ns / 1ps
`include "bicubic_alpha_upscale_core_macros.svh"
module bau_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_opcode,
   output logic             req_stall,
   output bau_pkg::cmd_type cmd,
   input  bau_pkg::sts_type sts
);
   import bau_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIVX,
      S_DIVY,
      S_KERN,
      S_TAPS,
      S_DRAIN,
      S_NORM,
      S_CMP,
      S_DIVF,
      S_DONE
   } state_type;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      cmd.div_sel   = DIV_POSX;
      cmd.res_sel   = RES_ZERO;
      cmd.kern_step = cnt_ff;
      cmd.tap_idx   = cnt_ff[3:0];
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid && req_opcode == OP_COMPUTE) begin
               state_in = S_DIVX;
               cnt_in   = '0;
            end
         end
         S_DIVX: begin
            cmd.div_sel   = DIV_POSX;
            cmd.div_start = (cnt_ff == '0);
            cnt_in        = 5'd1;
            if (sts.div_done) begin
               state_in = S_DIVY;
               cnt_in   = '0;
            end
         end
         S_DIVY: begin
            cmd.div_sel   = DIV_POSY;
            cmd.div_start = (cnt_ff == '0);
            cnt_in        = 5'd1;
            if (sts.div_done) begin
               state_in = S_KERN;
               cnt_in   = '0;
            end
         end
         S_KERN: begin
            cmd.kern_en   = 1'b1;
            cmd.acc_clear = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
            if (cnt_ff == 5'd31) begin
               state_in = S_TAPS;
               cnt_in   = '0;
            end
         end
         S_TAPS: begin
            cmd.tap_en = 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == 5'd15) begin
               state_in = S_DRAIN;
               cnt_in   = '0;
            end
         end
         S_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            cmd.norm_load = 1'b1;
            state_in      = S_CMP;
         end
         S_CMP: begin
            if (sts.res_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_ZERO;
               state_in     = S_DONE;
            end else if (sts.res_full) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_FULL;
               state_in     = S_DONE;
            end else begin
               state_in = S_DIVF;
               cnt_in   = '0;
            end
         end
         S_DIVF: begin
            cmd.div_sel   = DIV_FINAL;
            cmd.div_start = (cnt_ff == '0);
            cnt_in        = 5'd1;
            if (sts.div_done) begin
               cmd.res_load = 1'b1;
               cmd.res_sel  = RES_DIV;
               state_in     = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   `BAU_ASSERT_NXT(a_divx_to_divy, state_ff == S_DIVX && sts.div_done, state_ff == S_DIVY)
   `BAU_ASSERT_IMP(a_out_slot_free, cmd.out_load, !sts.rsp_busy)
   `BAU_ASSERT_IMP(a_norm_after_drain, state_ff == S_NORM, !sts.pipe_busy)
   `BAU_ASSERT_IMP(a_no_start_when_done, cmd.div_start, !sts.div_done)

endmodule

// File: tb/bicubic_alpha_upscale_core_test.sv
// Self-checking testbench of the bicubic alpha upscaler core
`timescale 1ns / 1ps
module bicubic_alpha_upscale_core_test;
   import bau_pkg::*;

   typedef struct {
      logic               op;
      logic [11:0]        x;
      logic [11:0]        y;
      logic signed [15:0] a;
   } pixel_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic                     req_opcode = OP_WRITE;
   logic [COORD_BITS-1:0]    req_coord_x = '0;
   logic [COORD_BITS-1:0]    req_coord_y = '0;
   logic signed [15:0]       req_alpha_sample = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_alpha_byte;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SOURCE_WIDTH;
   logic [CSR_DATA_BITS-1:0] csr_write_data = '0;

   pixel_beat_type     pending_beats[$];
   logic [7:0]         expected_bytes[$];
   logic signed [15:0] mask_mem[int];
   bit                 loaded[int];
   int                 fails = 0;

   // register copies seen by the predictor
   logic [10:0] pr_src_w = 11'd1024, pr_src_h = 11'd1024;
   logic [12:0] pr_tgt_w = 13'd1024, pr_tgt_h = 13'd1024;
   // register copies used while building stimulus
   logic [10:0] gen_src_w = 11'd1024, gen_src_h = 11'd1024;
   logic [12:0] gen_tgt_w = 13'd1024, gen_tgt_h = 13'd1024;

   bit beat_taken = 0;
   bit byte_taken = 0;
   int gap_left = 0;
   int stall_left = 0;
   bit send_burst = 0;
   bit recv_burst = 0;
   int phase_items;

   bicubic_alpha_upscale_core DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_opcode(req_opcode),
      .req_coord_x(req_coord_x), .req_coord_y(req_coord_y),
      .req_alpha_sample(req_alpha_sample),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_alpha_byte(rsp_alpha_byte),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #5 clock = ~clock;

   // zero counts as one, oversize saturates
   function automatic longint side_of(longint v, longint maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   // source position in Q16 with half-pixel alignment
   function automatic longint src_pos(longint c, longint s, longint d);
      return ((2 * c + 1) * s * 65536 + d) / (2 * d) - 32768;
   endfunction

   function automatic longint edge_clamp(longint v, longint hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   // Keys kernel at distance d (Q16), rounded to Q1.14
   function automatic longint keys_q14(longint d);
      longint d2, d3, w;
      d2 = d * d;
      d3 = d2 * d;
      if (d < 65536)
         w = 3 * d3 - 5 * (d2 * 65536) + (longint'(1) << 49);
      else if (d < 131072)
         w = -d3 + 5 * (d2 * 65536) - 8 * (d * (longint'(1) << 32)) + (longint'(1) << 50);
      else
         return 0;
      return ((w + (longint'(1) << 34) + (longint'(1) << 49)) >>> 35) - 16384;
   endfunction

   function automatic logic [7:0] upscale_alpha(longint x, longint y);
      longint sw, sh, dw, dh, px, py, ix, iy, tx, ty, sum, norm, w, s;
      longint wx[4], wy[4];
      sw = side_of(pr_src_w, MAX_SOURCE_SIDE);
      sh = side_of(pr_src_h, MAX_SOURCE_SIDE);
      dw = side_of(pr_tgt_w, MAX_TARGET_SIDE);
      dh = side_of(pr_tgt_h, MAX_TARGET_SIDE);
      px = src_pos(x, sw, dw) + 65536;
      py = src_pos(y, sh, dh) + 65536;
      ix = (px >>> 16) - 1;
      iy = (py >>> 16) - 1;
      tx = px & 64'hFFFF;
      ty = py & 64'hFFFF;
      wx[0] = keys_q14(tx + 65536); wx[1] = keys_q14(tx);
      wx[2] = keys_q14(65536 - tx); wx[3] = keys_q14(131072 - tx);
      wy[0] = keys_q14(ty + 65536); wy[1] = keys_q14(ty);
      wy[2] = keys_q14(65536 - ty); wy[3] = keys_q14(131072 - ty);
      sum = 0;
      norm = 0;
      for (int ky = 0; ky < 4; ky++) begin
         for (int kx = 0; kx < 4; kx++) begin
            int adr;
            adr = int'(edge_clamp(iy + ky - 1, sh - 1) * MAX_SOURCE_SIDE
                       + edge_clamp(ix + kx - 1, sw - 1));
            s = mask_mem.exists(adr) ? longint'(mask_mem[adr]) : 0;
            w = wy[ky] * wx[kx];
            sum += s * w;
            norm += w;
         end
      end
      if (norm == 0) return 8'd0;
      if (norm < 0) begin
         norm = -norm;
         sum = -sum;
      end
      if (sum <= 0) return 8'd0;
      if (sum >= norm * 4096) return 8'd255;
      return 8'((sum * 510 + norm * 4096) / (norm * 8192));
   endfunction

   task automatic report_mismatch(input logic [7:0] got, input logic [7:0] want);
      fails++;
      $display("alpha_byte mismatch: got %0d, expected %0d", got, want);
   endtask

   // queue one write beat, tracking which entries hold data
   task automatic push_write(input int x, input int y, input logic signed [15:0] a);
      pixel_beat_type b;
      b.op = OP_WRITE;
      b.x = 12'(x);
      b.y = 12'(y);
      b.a = a;
      pending_beats.push_back(b);
      phase_items++;
      if (x < side_of(gen_src_w, MAX_SOURCE_SIDE) && y < side_of(gen_src_h, MAX_SOURCE_SIDE))
         loaded[y * MAX_SOURCE_SIDE + x] = 1;
   endtask

   // load any unwritten neighbour, then queue the compute beat
   task automatic push_compute(input int x, input int y);
      pixel_beat_type b;
      longint sw, sh, ix, iy, cx, cy;
      sw = side_of(gen_src_w, MAX_SOURCE_SIDE);
      sh = side_of(gen_src_h, MAX_SOURCE_SIDE);
      ix = ((src_pos(x, sw, side_of(gen_tgt_w, MAX_TARGET_SIDE)) + 65536) >>> 16) - 1;
      iy = ((src_pos(y, sh, side_of(gen_tgt_h, MAX_TARGET_SIDE)) + 65536) >>> 16) - 1;
      for (int ky = 0; ky < 4; ky++) begin
         for (int kx = 0; kx < 4; kx++) begin
            cy = edge_clamp(iy + ky - 1, sh - 1);
            cx = edge_clamp(ix + kx - 1, sw - 1);
            if (!loaded.exists(int'(cy * MAX_SOURCE_SIDE + cx)))
               push_write(int'(cx), int'(cy), 16'($urandom));
         end
      end
      b.op = OP_COMPUTE;
      b.x = 12'(x);
      b.y = 12'(y);
      b.a = 16'($urandom);
      pending_beats.push_back(b);
      phase_items++;
   endtask

   // wait for the block to drain, then write all four size registers
   task automatic set_sizes(input logic [12:0] sw, input logic [12:0] sh,
                            input logic [12:0] tw, input logic [12:0] th);
      logic [12:0] vals[4];
      logic [CSR_IDX_BITS-1:0] idx[4];
      vals = '{sw, sh, tw, th};
      idx = '{CSR_SOURCE_WIDTH, CSR_SOURCE_HEIGHT, CSR_TARGET_WIDTH, CSR_TARGET_HEIGHT};
      wait (pending_beats.size() == 0 && expected_bytes.size() == 0 && !req_valid);
      repeat (200) @(negedge clock);
      for (int i = 0; i < 4; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_write_data <= vals[i];
         @(negedge clock);
      end
      csr_write_enable <= 1'b0;
      gen_src_w = sw[10:0];
      gen_src_h = sh[10:0];
      gen_tgt_w = tw;
      gen_tgt_h = th;
      phase_items = 0;
   endtask

   // random mix: mostly loaded neighbourhoods followed by a compute, some noise writes
   task automatic random_phase(input int budget);
      int tw, th, sw, sh, r;
      sw = int'(side_of(gen_src_w, MAX_SOURCE_SIDE));
      sh = int'(side_of(gen_src_h, MAX_SOURCE_SIDE));
      tw = int'(side_of(gen_tgt_w, MAX_TARGET_SIDE));
      th = int'(side_of(gen_tgt_h, MAX_TARGET_SIDE));
      while (phase_items < budget) begin
         r = $urandom_range(0, 9);
         if (r == 0)
            push_write($urandom_range(0, 4095), $urandom_range(0, 4095), 16'($urandom));
         else if (r == 1)
            push_write($urandom_range(0, sw - 1), $urandom_range(0, sh - 1), 16'($urandom));
         else if (r < 4)
            push_compute($urandom_range(0, 4095), $urandom_range(0, 4095));
         else
            push_compute($urandom_range(0, tw - 1), $urandom_range(0, th - 1));
      end
   endtask

   // check results and predict on accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            byte_taken = 1;
            if (expected_bytes.size() == 0) begin
               fails++;
               $display("unexpected alpha_byte %0d", rsp_alpha_byte);
            end else begin
               logic [7:0] want;
               want = expected_bytes.pop_front();
               if (rsp_alpha_byte !== want) report_mismatch(rsp_alpha_byte, want);
            end
         end
         if (req_valid && !req_stall) begin
            beat_taken = 1;
            if (req_opcode == OP_COMPUTE)
               expected_bytes.push_back(upscale_alpha(req_coord_x, req_coord_y));
            else if (req_coord_x < side_of(pr_src_w, MAX_SOURCE_SIDE)
                     && req_coord_y < side_of(pr_src_h, MAX_SOURCE_SIDE))
               mask_mem[req_coord_y * MAX_SOURCE_SIDE + req_coord_x] = req_alpha_sample;
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SOURCE_WIDTH: begin
                  pr_src_w = csr_write_data[10:0];
               end
               CSR_SOURCE_HEIGHT: begin
                  pr_src_h = csr_write_data[10:0];
               end
               CSR_TARGET_WIDTH: begin
                  pr_tgt_w = csr_write_data;
               end
               default: begin
                  pr_tgt_h = csr_write_data;
               end
            endcase
         end
      end
   end

   // drive request beats with random gaps
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && !beat_taken)) begin
         beat_taken = 0;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_beats.size() > 0) begin
            pixel_beat_type b;
            b = pending_beats.pop_front();
            req_opcode <= b.op;
            req_coord_x <= b.x;
            req_coord_y <= b.y;
            req_alpha_sample <= b.a;
            req_valid <= 1'b1;
            if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
            gap_left = send_burst ? 0 : $urandom_range(0, 8);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // stall the result side with random holds
   always @(negedge clock) begin
      if (byte_taken) begin
         byte_taken = 0;
         if ($urandom_range(0, 15) == 0) recv_burst = !recv_burst;
         stall_left = recv_burst ? 0 : $urandom_range(0, 8);
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: 4x4 source to 8x8 target, extreme samples, edges and ignored writes
      set_sizes(13'd4, 13'd4, 13'd8, 13'd8);
      for (int i = 0; i < 16; i++) begin
         case (i % 4)
            0: push_write(i % 4, i / 4, 16'sh7FFF);
            1: push_write(i % 4, i / 4, -16'sh8000);
            2: push_write(i % 4, i / 4, 16'sh1000);
            default: push_write(i % 4, i / 4, 16'sh0000);
         endcase
      end
      push_write(4, 0, 16'sh7FFF);
      push_write(4095, 4095, -16'sh8000);
      push_compute(0, 0);
      push_compute(7, 7);
      push_compute(3, 4);
      push_compute(4095, 4095);
      push_compute(0, 4095);

      // minimum sizes
      set_sizes(13'd1, 13'd1, 13'd1, 13'd1);
      random_phase(40);
      // maximum sizes, neighbourhoods loaded on demand
      set_sizes(13'd1024, 13'd1024, 13'd4096, 13'd4096);
      random_phase(70);
      // zero registers count as one
      set_sizes(13'd0, 13'd0, 13'd0, 13'd0);
      random_phase(30);
      // oversize registers saturate
      set_sizes(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
      random_phase(50);
      // upper data bits dropped by the source registers
      set_sizes(13'h1805, 13'h1003, 13'd13, 13'd3);
      random_phase(40);
      for (int p = 0; p < 5; p++) begin
         set_sizes(13'($urandom_range(1, 16)), 13'($urandom_range(1, 16)),
                   13'($urandom_range(1, 64)), 13'($urandom_range(1, 64)));
         random_phase(80);
      end

      wait (pending_beats.size() == 0 && expected_bytes.size() == 0 && !req_valid);
      repeat (300) @(negedge clock);
      if (fails == 0) begin
         $display("[bicubic_alpha_upscale_core] OK");
      end else begin
         $display("[bicubic_alpha_upscale_core] ERROR");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[bicubic_alpha_upscale_core] ERROR");
      $finish;
   end

endmodule
